>>> sv/tcp_oae_pkg.sv
package tcp_oae_pkg;

  localparam logic [7:0] MATCH_KIND_RST  = 8'd200;
  localparam logic [7:0] OPT_EOL         = 8'd0;
  localparam logic [7:0] OPT_NOP         = 8'd1;
  localparam logic [7:0] TARGET_OPT_SIZE = 8'd8;
  localparam logic [7:0] MIN_OPT_SIZE    = 8'd2;
  localparam logic [5:0] BASE_HDR_BYTES  = 6'd20;
  localparam logic [3:0] BASE_HDR_WORDS  = 4'd5;
  localparam logic [2:0] LAST_CAPTURE    = 3'd5;

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_BYTE   = 1'b1;

  localparam logic VERDICT_FOUND      = 1'b0;
  localparam logic VERDICT_NOT_NEEDED = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_KIND    = 3'd1,
    PH_SIZE    = 3'd2,
    PH_SKIP    = 3'd3,
    PH_CAPTURE = 3'd4
  } phase_t;

  typedef struct packed {
    logic        command;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [3:0]  data_offset;
    logic [7:0]  option_byte;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic        verdict;
    logic [31:0] target_addr;
    logic [15:0] target_port;
  } result_t;

endpackage

>>> sv/tcp_oae_walker.sv
module tcp_oae_walker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  tcp_oae_pkg::item_t  item,
  input  logic [7:0]          match_kind,
  output tcp_oae_pkg::result_t result
);

  tcp_oae_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]  bytes_left_r, bytes_left_nxt;
  logic [5:0]  skip_count_r, skip_count_nxt;
  logic [2:0]  capture_index_r, capture_index_nxt;
  logic [7:0]  current_kind_r, current_kind_nxt;
  logic [47:0] captured_r, captured_nxt;
  logic [31:0] saved_addr_r, saved_addr_nxt;
  logic [15:0] saved_port_r, saved_port_nxt;

  logic [7:0]  b;
  logic [5:0]  bl_dec;
  logic [5:0]  skip_dec;
  logic [7:0]  bytes_left_ext;
  logic [47:0] shifted;

  assign b              = item.option_byte;
  assign bl_dec         = bytes_left_r - 6'd1;
  assign skip_dec       = skip_count_r - 6'd1;
  assign bytes_left_ext = {2'b00, bytes_left_r};
  assign shifted        = {captured_r[39:0], b};

  // Next state
  always_comb begin
    phase_nxt         = phase_r;
    bytes_left_nxt    = bytes_left_r;
    skip_count_nxt    = skip_count_r;
    capture_index_nxt = capture_index_r;
    current_kind_nxt  = current_kind_r;
    captured_nxt      = captured_r;
    saved_addr_nxt    = saved_addr_r;
    saved_port_nxt    = saved_port_r;
    if (item.command == tcp_oae_pkg::CMD_HEADER) begin
      saved_addr_nxt    = item.src_addr;
      saved_port_nxt    = item.src_port;
      skip_count_nxt    = '0;
      capture_index_nxt = '0;
      captured_nxt      = '0;
      current_kind_nxt  = '0;
      if (item.data_offset <= tcp_oae_pkg::BASE_HDR_WORDS) begin
        bytes_left_nxt = '0;
        phase_nxt      = tcp_oae_pkg::PH_IDLE;
      end else begin
        bytes_left_nxt = {item.data_offset, 2'b00} - tcp_oae_pkg::BASE_HDR_BYTES;
        phase_nxt      = tcp_oae_pkg::PH_KIND;
      end
    end else begin
      unique case (phase_r)
        tcp_oae_pkg::PH_KIND: begin
          if (b == tcp_oae_pkg::OPT_EOL) begin
            phase_nxt = tcp_oae_pkg::PH_IDLE;
          end else if (b == tcp_oae_pkg::OPT_NOP) begin
            bytes_left_nxt = bl_dec;
            phase_nxt = (bl_dec == '0) ? tcp_oae_pkg::PH_IDLE : tcp_oae_pkg::PH_KIND;
          end else begin
            current_kind_nxt = b;
            phase_nxt = (bytes_left_r <= 6'd1) ? tcp_oae_pkg::PH_IDLE
                                               : tcp_oae_pkg::PH_SIZE;
          end
        end
        tcp_oae_pkg::PH_SIZE: begin
          if (b < tcp_oae_pkg::MIN_OPT_SIZE || b > bytes_left_ext) begin
            phase_nxt = tcp_oae_pkg::PH_IDLE;
          end else if (current_kind_r == match_kind &&
                       b == tcp_oae_pkg::TARGET_OPT_SIZE) begin
            capture_index_nxt = '0;
            captured_nxt      = '0;
            phase_nxt         = tcp_oae_pkg::PH_CAPTURE;
          end else begin
            bytes_left_nxt = bytes_left_r - b[5:0];
            skip_count_nxt = b[5:0] - tcp_oae_pkg::MIN_OPT_SIZE[5:0];
            if (b == tcp_oae_pkg::MIN_OPT_SIZE) begin
              phase_nxt = (bytes_left_nxt == '0) ? tcp_oae_pkg::PH_IDLE
                                                 : tcp_oae_pkg::PH_KIND;
            end else begin
              phase_nxt = tcp_oae_pkg::PH_SKIP;
            end
          end
        end
        tcp_oae_pkg::PH_SKIP: begin
          skip_count_nxt = skip_dec;
          if (skip_dec == '0) begin
            phase_nxt = (bytes_left_r == '0) ? tcp_oae_pkg::PH_IDLE
                                             : tcp_oae_pkg::PH_KIND;
          end
        end
        tcp_oae_pkg::PH_CAPTURE: begin
          captured_nxt      = shifted;
          capture_index_nxt = capture_index_r + 3'd1;
          if (capture_index_r == tcp_oae_pkg::LAST_CAPTURE) begin
            phase_nxt = tcp_oae_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // Result: a verdict whenever an active walk drops back to idle, or when a header carries no options
  always_comb begin
    result             = '0;
    result.verdict     = tcp_oae_pkg::VERDICT_NOT_NEEDED;
    if (item.command == tcp_oae_pkg::CMD_HEADER) begin
      result.valid = (phase_nxt == tcp_oae_pkg::PH_IDLE);
    end else begin
      result.valid = (phase_r != tcp_oae_pkg::PH_IDLE) &&
                     (phase_nxt == tcp_oae_pkg::PH_IDLE);
      if (phase_r == tcp_oae_pkg::PH_CAPTURE &&
          !(shifted[31:0] == saved_addr_r && shifted[47:32] == saved_port_r)) begin
        result.verdict     = tcp_oae_pkg::VERDICT_FOUND;
        result.target_addr = shifted[31:0];
        result.target_port = shifted[47:32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= tcp_oae_pkg::PH_IDLE;
      bytes_left_r    <= '0;
      skip_count_r    <= '0;
      capture_index_r <= '0;
      current_kind_r  <= '0;
      captured_r      <= '0;
      saved_addr_r    <= '0;
      saved_port_r    <= '0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      bytes_left_r    <= bytes_left_nxt;
      skip_count_r    <= skip_count_nxt;
      capture_index_r <= capture_index_nxt;
      current_kind_r  <= current_kind_nxt;
      captured_r      <= captured_nxt;
      saved_addr_r    <= saved_addr_nxt;
      saved_port_r    <= saved_port_nxt;
    end
  end

endmodule

>>> sv/tcp_option_address_extractor_unit.sv
// TCP option rewrite-target extractor.
// Input channel (in_valid/in_ready): a header item (in_command = 0) starts a
// packet with source address, source port and data offset; each byte item
// (in_command = 1) carries the next byte of the options area.
// Output channel (out_valid/out_ready): one verdict per packet, with the
// target address and port when an option of kind match_kind and size 8 holds
// a target that differs from the source; otherwise verdict 1 and zeros.
// cfg_wr_en/cfg_wr_data write match_kind (reset 200); write only while idle.
// An accepted item is held in the input register; when an item that ends a
// packet advances, the result register loads the walker's verdict, which
// then stays on out_* until out_ready takes it.
// Throughput: one item per cycle unless stalled; each byte is one small state
// update in the walker between the input register and the result register.
// Stall: while a result waits in the result register and out_ready is low,
// the input register holds and in_ready drops once it is also full.
// Reset: synchronous, active low; clears the walk state, both valid flags and
// restores match_kind to 200.
module tcp_option_address_extractor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [31:0] in_src_addr,
  input  logic [15:0] in_src_port,
  input  logic [3:0]  in_data_offset,
  input  logic [7:0]  in_option_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_verdict,
  output logic [31:0] out_target_addr,
  output logic [15:0] out_target_port,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic                 in_valid_r;
  tcp_oae_pkg::item_t   item_r;
  logic [7:0]           match_kind_r;
  logic                 out_valid_r;
  logic                 verdict_r;
  logic [31:0]          target_addr_r;
  logic [15:0]          target_port_r;
  logic                 advance;
  tcp_oae_pkg::result_t result;

  // The held item moves on when the result register is free or draining.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_kind_r <= tcp_oae_pkg::MATCH_KIND_RST;
    end else if (cfg_wr_en) begin
      match_kind_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.command     <= in_command;
      item_r.src_addr    <= in_src_addr;
      item_r.src_port    <= in_src_port;
      item_r.data_offset <= in_data_offset;
      item_r.option_byte <= in_option_byte;
    end
  end

  tcp_oae_walker u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .item       (item_r),
    .match_kind (match_kind_r),
    .result     (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && result.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      verdict_r     <= result.verdict;
      target_addr_r <= result.target_addr;
      target_port_r <= result.target_port;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_verdict     = verdict_r;
  assign out_target_addr = target_addr_r;
  assign out_target_port = target_port_r;

endmodule
